// ----- hw/rtl/ific_pkg.sv -----
// shared types, register offsets and constants of the two-bank interrupt controller
package ific_pkg;

   localparam int DATA_W      = 32;
   localparam int OFFSET_W    = 10;
   localparam int MAX_SOURCES = 32;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_RAISE = 2'd2,
      OP_DROP  = 2'd3
   } ific_op_type;

   // banked registers, low byte of the offset (bit 8 picks the bank)
   localparam logic [7:0] REG_CURRENT  = 8'h00;
   localparam logic [7:0] REG_ACTIVE   = 8'h04;
   localparam logic [7:0] REG_ENABLE   = 8'h08;
   localparam logic [7:0] REG_DISABLE  = 8'h0C;
   localparam logic [7:0] REG_ZERO_A   = 8'h20;
   localparam logic [7:0] REG_TYPE     = 8'h24;
   localparam logic [7:0] REG_ZERO_B   = 8'h28;
   localparam logic [7:0] REG_WR_SINK  = 8'h2C;

   // upper window, full offsets
   localparam logic [OFFSET_W-1:0] OFF_MISC_0 = 10'h200;
   localparam logic [OFFSET_W-1:0] OFF_MISC_1 = 10'h204;
   localparam logic [OFFSET_W-1:0] OFF_MISC_2 = 10'h208;
   localparam logic [OFFSET_W-1:0] OFF_SINK_0 = 10'h304;
   localparam logic [OFFSET_W-1:0] OFF_SINK_1 = 10'h30C;
   localparam logic [OFFSET_W-1:0] OFF_SINK_2 = 10'h31C;
   localparam logic [OFFSET_W-1:0] OFF_SINK_3 = 10'h320;
   localparam logic [OFFSET_W-1:0] OFF_SINK_4 = 10'h324;
   localparam logic [OFFSET_W-1:0] OFF_SINK_5 = 10'h32C;
   localparam logic [OFFSET_W-1:0] OFF_SINK_6 = 10'h338;
   localparam logic [OFFSET_W-1:0] OFF_SINK_7 = 10'h340;
   localparam logic [OFFSET_W-1:0] OFF_SINK_8 = 10'h348;
   localparam logic [OFFSET_W-1:0] OFF_SINK_9 = 10'h34C;
   localparam logic [OFFSET_W-1:0] OFF_SINK_A = 10'h358;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              bad_access;
      logic              no_interrupt;
      logic              irq_request;
      logic              fiq_request;
   } ific_result_type;

endpackage

// ----- hw/rtl/ific_req_if.sv -----
// request channel: register accesses and source events
interface ific_req_if
   import ific_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [1:0]          opcode;
   logic [OFFSET_W-1:0] register_offset;
   logic [DATA_W-1:0]   data_value;

   modport source (output valid, opcode, register_offset, data_value, input ready);
   modport sink   (input valid, opcode, register_offset, data_value, output ready);
endinterface

// ----- hw/rtl/ific_rsp_if.sv -----
// response channel: read data, flags and request lines
interface ific_rsp_if
   import ific_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              bad_access;
   logic              no_interrupt;
   logic              irq_request;
   logic              fiq_request;

   modport source (output valid, read_data, bad_access, no_interrupt, irq_request,
                   fiq_request, input ready);
   modport sink   (input valid, read_data, bad_access, no_interrupt, irq_request,
                   fiq_request, output ready);
endinterface

// ----- hw/rtl/ific_regs.sv -----
// controller state registers, address decode and result word
module ific_regs
   import ific_pkg::*;
#(
   parameter int NUM_SOURCES = MAX_SOURCES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            opcode,
   input  logic [OFFSET_W-1:0]   register_offset,
   input  logic [DATA_W-1:0]     data_value,
   output ific_result_type       result
);

   localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

   logic [NUM_SOURCES-1:0] active_ff, active_in;
   logic [NUM_SOURCES-1:0] current_ff [2];
   logic [NUM_SOURCES-1:0] current_in [2];
   logic [NUM_SOURCES-1:0] enable_ff [2];
   logic [NUM_SOURCES-1:0] enable_in [2];

   logic [NUM_SOURCES-1:0] mask;
   logic                   bank;
   logic [7:0]             low_off;
   logic [NUM_SOURCES-1:0] cur_sel;
   logic [IDX_W-1:0]       lowest;
   logic                   any_cur;
   ific_op_type            op;

   assign mask    = data_value[NUM_SOURCES-1:0];
   assign bank    = register_offset[8];
   assign low_off = register_offset[7:0];
   assign cur_sel = current_ff[bank];
   assign op      = ific_op_type'(opcode);
   assign any_cur = |cur_sel;

   // lowest set source of the selected bank
   always_comb begin
      lowest = '0;
      for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
         if (cur_sel[i]) begin
            lowest = IDX_W'(i);
         end
      end
   end

   always_comb begin
      active_in     = active_ff;
      current_in[0] = current_ff[0];
      current_in[1] = current_ff[1];
      enable_in[0]  = enable_ff[0];
      enable_in[1]  = enable_ff[1];
      result        = '0;

      case (op)
         OP_READ: begin
            if (!register_offset[9]) begin
               case (low_off)
                  REG_CURRENT: result.read_data = DATA_W'(cur_sel);
                  REG_ACTIVE:  result.read_data = DATA_W'(active_ff);
                  REG_ENABLE, REG_DISABLE: result.read_data = DATA_W'(enable_ff[bank]);
                  REG_ZERO_A, REG_ZERO_B: result.read_data = '0;
                  REG_TYPE: begin
                     result.no_interrupt = !any_cur;
                     result.read_data    = any_cur ? DATA_W'(lowest) : '0;
                  end
                  default: result.bad_access = 1'b1;
               endcase
            end else begin
               case (register_offset)
                  OFF_MISC_0, OFF_MISC_1, OFF_MISC_2: result.read_data = '0;
                  default: result.bad_access = 1'b1;
               endcase
            end
         end
         OP_WRITE: begin
            if (!register_offset[9]) begin
               case (low_off)
                  REG_ACTIVE: begin
                     // acknowledge clears masked bits unless their source is still active and enabled
                     current_in[bank] = cur_sel & (~mask | (active_ff & enable_ff[bank]));
                  end
                  REG_ENABLE: begin
                     enable_in[bank]  = enable_ff[bank] | mask;
                     current_in[bank] = cur_sel | (active_ff & (enable_ff[bank] | mask));
                  end
                  REG_DISABLE: enable_in[bank] = enable_ff[bank] & ~mask;
                  REG_WR_SINK: result.bad_access = 1'b0;
                  default: result.bad_access = 1'b1;
               endcase
            end else begin
               case (register_offset)
                  OFF_MISC_0, OFF_MISC_1, OFF_MISC_2, OFF_SINK_0, OFF_SINK_1,
                  OFF_SINK_2, OFF_SINK_3, OFF_SINK_4, OFF_SINK_5, OFF_SINK_6,
                  OFF_SINK_7, OFF_SINK_8, OFF_SINK_9, OFF_SINK_A:
                     result.bad_access = 1'b0;
                  default: result.bad_access = 1'b1;
               endcase
            end
         end
         OP_RAISE: begin
            active_in     = active_ff | mask;
            current_in[0] = current_ff[0] | (mask & enable_ff[0]);
            current_in[1] = current_ff[1] | (mask & enable_ff[1]);
         end
         OP_DROP: active_in = active_ff & ~mask;
         default: result.bad_access = 1'b1;
      endcase

      result.irq_request = |current_in[0];
      result.fiq_request = |current_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         current_ff[0] <= '0;
         current_ff[1] <= '0;
         enable_ff[0]  <= '0;
         enable_ff[1]  <= '0;
      end else if (accept) begin
         active_ff     <= active_in;
         current_ff[0] <= current_in[0];
         current_ff[1] <= current_in[1];
         enable_ff[0]  <= enable_in[0];
         enable_ff[1]  <= enable_in[1];
      end
   end

endmodule

// ----- hw/rtl/irq_fiq_interrupt_controller_top.sv -----
// two-bank irq/fiq interrupt controller, top level with response register
// the response is registered, valid in the cycle after its word is accepted
// throughput: one word per cycle while responses are taken; update and decode
// finish in the accept cycle; the response register frees as its word is taken
// reset: synchronous, clears source, current and enable words and the response
// register; the block accepts words in the first cycle after reset
module irq_fiq_interrupt_controller_top
   import ific_pkg::*;
#(
   parameter int NUM_SOURCES = MAX_SOURCES
) (
   input  logic        clock,
   input  logic        reset,
   ific_req_if.sink    req_chan,
   ific_rsp_if.source  rsp_chan
);

   logic            accept;
   ific_result_type result;
   ific_result_type rsp_data_ff;
   logic            rsp_valid_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   ific_regs #(
      .NUM_SOURCES(NUM_SOURCES)
   ) u_regs (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .opcode          (req_chan.opcode),
      .register_offset (req_chan.register_offset),
      .data_value      (req_chan.data_value),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         rsp_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_data_ff <= '0;
      end else if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.read_data    = rsp_data_ff.read_data;
   assign rsp_chan.bad_access   = rsp_data_ff.bad_access;
   assign rsp_chan.no_interrupt = rsp_data_ff.no_interrupt;
   assign rsp_chan.irq_request  = rsp_data_ff.irq_request;
   assign rsp_chan.fiq_request  = rsp_data_ff.fiq_request;

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid right after reset");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.bad_access && rsp_data_ff.no_interrupt))
      else $error("bad access and no interrupt both set");

   a_empty_type_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.no_interrupt) |-> (rsp_data_ff.read_data == '0))
      else $error("empty type read returned nonzero data");

   a_accept_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no response");

endmodule
